>>> sv/aodo_pkg.sv
// ----------------------------------------------------------------------------
// aodo_pkg
// Shared types, constants and tables of the Ackermann wheel odometry block.
// ----------------------------------------------------------------------------
package aodo_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int TRIG_ITERATIONS = 16;

  localparam int CORDIC_AW    = ANGLE_BITS + 2;
  localparam int CORDIC_CNT_W = $clog2(TRIG_ITERATIONS);
  localparam int ATAN_IDX_W   = 5;
  localparam int ANG_UP       = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int ANG_DN       = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam int ATAN_SH      = 32 - ANGLE_BITS;

  localparam logic signed [CORDIC_AW-1:0] CORDIC_HALF    = CORDIC_AW'(1) << (ANGLE_BITS - 1);
  localparam logic signed [CORDIC_AW-1:0] CORDIC_QUARTER = CORDIC_AW'(1) << (ANGLE_BITS - 2);

  localparam logic [31:0] ATAN_TAB [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  localparam logic [31:0] GAIN_TAB [17] = '{
    32'd652039508, 32'd652034533, 32'd652033289, 32'd652032978, 32'd652032900,
    32'd652032881, 32'd652032876, 32'd652032875, 32'd652032875, 32'd652032875,
    32'd652032875, 32'd652032875, 32'd652032875, 32'd652032875, 32'd652032875,
    32'd652032875, 32'd652032875
  };

  localparam logic signed [31:0] CORDIC_GAIN = GAIN_TAB[TRIG_ITERATIONS-8];

  function automatic logic signed [CORDIC_AW-1:0] cordic_step_angle(
    input logic [ATAN_IDX_W-1:0] idx
  );
    logic [32:0] s;
    s = {1'b0, ATAN_TAB[idx]} + (33'd1 << (ATAN_SH - 1));
    s = s >> ATAN_SH;
    return s[CORDIC_AW-1:0];
  endfunction

  // serial multiply / divide unit
  localparam int MUL_A_W  = 65;
  localparam int MUL_B_W  = 32;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W  = 80;
  localparam int DIV_D_W  = 40;
  localparam int DIV_Q_W  = 33;
  localparam int MD_CNT_W = 7;

  localparam logic [31:0] INV_PI_Q32 = 32'd1367130551;
  localparam logic [31:0] US_PER_S   = 32'd1000000;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 24;
  localparam logic [CFG_IDX_W-1:0] REG_MPP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WB  = 1'b1;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NO_DT  = 2'd1;
  localparam logic [1:0] STAT_POSSAT = 2'd2;

  typedef struct packed {
    logic start;
    logic div;
  } md_cmd_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } md_rsp_t;

  typedef struct packed {
    logic signed [31:0] tacho_count;
    logic signed [15:0] steer_angle;
    logic [23:0]        elapsed_us;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] heading_out;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] yaw_rate;
    logic [31:0]        seq_number;
    logic [1:0]         status;
  } out_t;

endpackage

>>> sv/aodo_cordic.sv
// ----------------------------------------------------------------------------
// aodo_cordic
// Iterative rotation CORDIC: cos and sin of a binary angle, Q16, one step
// per cycle.
// ----------------------------------------------------------------------------
module aodo_cordic import aodo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               done,
  output logic signed [17:0] cos_q16,
  output logic signed [17:0] sin_q16
);

  logic                          busy;
  logic [CORDIC_CNT_W-1:0]       cnt;
  logic signed [CORDIC_AW-1:0]   a;
  logic signed [31:0]            x;
  logic signed [31:0]            y;
  logic                          flip;

  logic signed [25:0]          a_wide;
  logic signed [25:0]          a_sh;
  logic signed [CORDIC_AW-1:0] a0;
  logic signed [CORDIC_AW-1:0] a_init;
  logic                        flip_init;
  logic signed [31:0]          dx;
  logic signed [31:0]          dy;
  logic signed [CORDIC_AW-1:0] t;
  logic signed [31:0]          xf;
  logic signed [31:0]          yf;

  always_comb begin
    a_wide = {{10{angle[15]}}, angle};
    a_sh   = (a_wide <<< ANG_UP) >>> ANG_DN;
    a0     = a_sh[CORDIC_AW-1:0];
    if (a0 > CORDIC_QUARTER) begin
      a_init    = a0 - CORDIC_HALF;
      flip_init = 1'b1;
    end else if (a0 < -CORDIC_QUARTER) begin
      a_init    = a0 + CORDIC_HALF;
      flip_init = 1'b1;
    end else begin
      a_init    = a0;
      flip_init = 1'b0;
    end
    dx = y >>> cnt;
    dy = x >>> cnt;
    t  = cordic_step_angle(ATAN_IDX_W'(cnt));
    xf = (flip ? -x : x) + 32'sd8192;
    yf = (flip ? -y : y) + 32'sd8192;
  end

  assign cos_q16 = xf[31:14];
  assign sin_q16 = yf[31:14];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        a    <= a_init;
        flip <= flip_init;
        x    <= CORDIC_GAIN;
        y    <= '0;
      end else if (busy) begin
        if (a >= 0) begin
          x <= x - dx;
          y <= y + dy;
          a <= a - t;
        end else begin
          x <= x + dx;
          y <= y - dy;
          a <= a + t;
        end
        if (cnt == CORDIC_CNT_W'(TRIG_ITERATIONS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/aodo_muldiv.sv
// ----------------------------------------------------------------------------
// aodo_muldiv
// Bit-serial unit: shift-add multiply (one multiplier bit per cycle) and
// restoring divide (one quotient bit per cycle) with quotient overflow flag.
// ----------------------------------------------------------------------------
module aodo_muldiv import aodo_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  md_cmd_t             cmd,
  input  logic [MUL_A_W-1:0]  mul_a,
  input  logic [MUL_B_W-1:0]  mul_b,
  input  logic [DIV_N_W-1:0]  num,
  input  logic [DIV_D_W-1:0]  den,
  output md_rsp_t             rsp,
  output logic [MUL_P_W-1:0]  prod,
  output logic [DIV_Q_W-1:0]  quo
);

  logic                busy;
  logic                mode_div;
  logic [MD_CNT_W-1:0] cnt;
  logic                done;
  logic [MUL_A_W-1:0]  a_r;
  logic [MUL_A_W:0]    hi;
  logic [MUL_B_W-1:0]  lo;
  logic [DIV_D_W-1:0]  den_r;
  logic [DIV_N_W-1:0]  n_r;
  logic [DIV_D_W-1:0]  r_r;
  logic [DIV_Q_W-1:0]  q_r;
  logic                ovf;

  logic [MUL_A_W:0]    sum;
  logic [DIV_D_W:0]    rs;
  logic [DIV_D_W:0]    diff;
  logic                ge;
  logic [MD_CNT_W-1:0] last;

  always_comb begin
    sum  = hi + (lo[0] ? {1'b0, a_r} : '0);
    rs   = {r_r, n_r[DIV_N_W-1]};
    ge   = rs >= {1'b0, den_r};
    diff = rs - {1'b0, den_r};
    last = mode_div ? MD_CNT_W'(DIV_N_W - 1) : MD_CNT_W'(MUL_B_W - 1);
  end

  assign prod = {hi[MUL_A_W-1:0], lo};
  assign quo  = q_r;
  assign rsp  = '{done: done, ovf: ovf};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy     <= 1'b1;
        mode_div <= cmd.div;
        cnt      <= '0;
        a_r      <= mul_a;
        hi       <= '0;
        lo       <= mul_b;
        den_r    <= den;
        n_r      <= num;
        r_r      <= '0;
        q_r      <= '0;
        ovf      <= 1'b0;
      end else if (busy) begin
        if (mode_div) begin
          r_r <= ge ? diff[DIV_D_W-1:0] : rs[DIV_D_W-1:0];
          n_r <= n_r << 1;
          q_r <= {q_r[DIV_Q_W-2:0], ge};
          ovf <= ovf | q_r[DIV_Q_W-1];
        end else begin
          hi <= {1'b0, sum[MUL_A_W:1]};
          lo <= {sum[0], lo[MUL_B_W-1:1]};
        end
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

>>> sv/ackermann_wheel_odometry_top.sv
// ----------------------------------------------------------------------------
// ackermann_wheel_odometry_top
// Bicycle-model dead reckoning from tachometer, steering and elapsed time.
// ----------------------------------------------------------------------------
// One word in gives one word out. Each word runs two CORDIC passes, then ten
// bit-serial multiplies and three bit-serial divides in turn on one shared
// multiply/divide unit; the input is taken in the idle state and the result
// is stored in the final state. in_ready is high while no word is in flight; a
// finished word waits in the output register without blocking the next input.
// Configuration writes take effect at once, so make them only while no word
// is in flight.
module ackermann_wheel_odometry_top import aodo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CH_GO   = 3'd1;
  localparam logic [2:0] S_CH_WAIT = 3'd2;
  localparam logic [2:0] S_CS_GO   = 3'd3;
  localparam logic [2:0] S_CS_WAIT = 3'd4;
  localparam logic [2:0] S_OP_GO   = 3'd5;
  localparam logic [2:0] S_OP_WAIT = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  localparam logic [3:0] OP_M24   = 4'd0;
  localparam logic [3:0] OP_STEPX = 4'd1;
  localparam logic [3:0] OP_STEPY = 4'd2;
  localparam logic [3:0] OP_DEN   = 4'd3;
  localparam logic [3:0] OP_HP    = 4'd4;
  localparam logic [3:0] OP_HN    = 4'd5;
  localparam logic [3:0] OP_HDIV  = 4'd6;
  localparam logic [3:0] OP_VN    = 4'd7;
  localparam logic [3:0] OP_VDIV  = 4'd8;
  localparam logic [3:0] OP_VX    = 4'd9;
  localparam logic [3:0] OP_VY    = 4'd10;
  localparam logic [3:0] OP_YN    = 4'd11;
  localparam logic [3:0] OP_YDIV  = 4'd12;

  logic [2:0]  state;
  logic [3:0]  op;

  logic [23:0] mpp;
  logic [22:0] wb;
  logic [31:0] prev_tacho;
  logic signed [31:0] x_accum;
  logic signed [31:0] y_accum;
  logic [15:0] heading_accum;
  logic [31:0] seq_counter;

  logic [31:0] mag;
  logic        neg;
  logic [15:0] steer;
  logic [23:0] el;

  logic signed [17:0] hc, hs, sc, ss;
  logic [55:0] m24;
  logic [48:0] stepx, stepy;
  logic [39:0] den;
  logic [64:0] hp;
  logic [78:0] hnum;
  logic [15:0] hq;
  logic [75:0] vnum;
  logic [31:0] vmag;
  logic [32:0] vxm, vym;
  logic [48:0] yn;
  logic [32:0] yq;
  logic        yovf;

  logic               cor_start;
  logic [15:0]        cor_angle;
  logic               cor_done;
  logic signed [17:0] cor_cos, cor_sin;

  md_cmd_t            md_cmd;
  md_rsp_t            md_rsp;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [DIV_N_W-1:0] num;
  logic [DIV_D_W-1:0] dnm;
  logic [MUL_P_W-1:0] prod;
  logic [DIV_Q_W-1:0] quo;

  logic [31:0] d;
  logic [16:0] hcm, hsm, scm, ssm;
  logic [47:0] m16;
  logic [32:0] vlim;
  logic        v_neg;
  logic        el_zero;
  logic [32:0] mx, my;
  logic        can_load;
  logic [15:0] heading_next;
  logic [1:0]  status_next;
  logic signed [31:0] vx_w, vy_w, yaw_w;

  function automatic logic [16:0] mag18(input logic signed [17:0] v);
    logic [17:0] n;
    n = v[17] ? -v : v;
    return n[16:0];
  endfunction

  function automatic logic [31:0] sat_s32(input logic [32:0] m, input logic o,
                                          input logic ng);
    logic [32:0] lim;
    logic [32:0] r;
    lim = ng ? 33'h080000000 : 33'h07FFFFFFF;
    r   = (o || m > lim) ? lim : m;
    return ng ? -r[31:0] : r[31:0];
  endfunction

  // {saturated, new accumulator}
  function automatic logic [32:0] move(input logic signed [31:0] acc, input logic ng,
                                       input logic [48:0] st);
    logic signed [50:0] s;
    s = {{19{acc[31]}}, acc};
    s = ng ? s - {2'b0, st} : s + {2'b0, st};
    if (s > 51'sd2147483647) begin
      return {1'b1, 32'h7FFFFFFF};
    end else if (s < -51'sd2147483648) begin
      return {1'b1, 32'h80000000};
    end
    return {1'b0, s[31:0]};
  endfunction

  aodo_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (cor_angle),
    .done    (cor_done),
    .cos_q16 (cor_cos),
    .sin_q16 (cor_sin)
  );

  aodo_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .cmd   (md_cmd),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .num   (num),
    .den   (dnm),
    .rsp   (md_rsp),
    .prod  (prod),
    .quo   (quo)
  );

  always_comb begin
    in_ready  = (state == S_IDLE);
    d         = in_word.tacho_count - prev_tacho;
    cor_start = (state == S_CH_GO) || (state == S_CS_GO);
    cor_angle = (state == S_CH_GO) ? heading_accum : steer;
    hcm       = mag18(hc);
    hsm       = mag18(hs);
    scm       = mag18(sc);
    ssm       = mag18(ss);
    m16       = m24[55:8];
    vlim      = neg ? 33'h080000000 : 33'h07FFFFFFF;
    v_neg     = neg && (vmag != '0);
    el_zero   = (el == '0);

    md_cmd = '{start: (state == S_OP_GO), div: 1'b0};
    mul_a  = '0;
    mul_b  = '0;
    num    = '0;
    dnm    = den;
    unique case (op)
      OP_M24: begin
        mul_a = {41'b0, mpp};
        mul_b = mag;
      end
      OP_STEPX: begin
        mul_a = {17'b0, m16};
        mul_b = {15'b0, hcm};
      end
      OP_STEPY: begin
        mul_a = {17'b0, m16};
        mul_b = {15'b0, hsm};
      end
      OP_DEN: begin
        mul_a = {42'b0, wb};
        mul_b = {15'b0, scm};
      end
      OP_HP: begin
        mul_a = {17'b0, m16};
        mul_b = {15'b0, ssm};
      end
      OP_HN: begin
        mul_a = hp;
        mul_b = INV_PI_Q32;
      end
      OP_HDIV: begin
        md_cmd.div = 1'b1;
        num        = {1'b0, hnum};
      end
      OP_VN: begin
        mul_a = {9'b0, m24};
        mul_b = US_PER_S;
      end
      OP_VDIV: begin
        md_cmd.div = 1'b1;
        num        = {4'b0, vnum};
        dnm        = {8'b0, el, 8'b0};
      end
      OP_VX: begin
        mul_a = {33'b0, vmag};
        mul_b = {15'b0, hcm};
      end
      OP_VY: begin
        mul_a = {33'b0, vmag};
        mul_b = {15'b0, hsm};
      end
      OP_YN: begin
        mul_a = {33'b0, vmag};
        mul_b = {15'b0, ssm};
      end
      OP_YDIV: begin
        md_cmd.div = 1'b1;
        num        = {15'b0, yn, 16'b0};
      end
      default: begin
        mul_a = '0;
      end
    endcase

    mx = move(x_accum, neg ^ hc[17], stepx);
    my = move(y_accum, neg ^ hs[17], stepy);

    if (m16 != '0 && ss != '0 && den != '0) begin
      heading_next = (neg ^ ss[17] ^ sc[17]) ? heading_accum - hq : heading_accum + hq;
    end else begin
      heading_next = heading_accum;
    end

    priority if (mx[32] || my[32]) begin
      status_next = STAT_POSSAT;
    end else if (el_zero) begin
      status_next = STAT_NO_DT;
    end else begin
      status_next = STAT_OK;
    end

    vx_w = el_zero ? '0 : sat_s32(vxm, 1'b0, v_neg ^ hc[17]);
    vy_w = el_zero ? '0 : sat_s32(vym, 1'b0, v_neg ^ hs[17]);
    priority if (el_zero || vmag == '0 || ss == '0) begin
      yaw_w = '0;
    end else if (den == '0) begin
      yaw_w = sat_s32('0, 1'b1, v_neg ^ ss[17]);
    end else begin
      yaw_w = sat_s32(yq, yovf, v_neg ^ ss[17] ^ sc[17]);
    end

    can_load = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      op            <= OP_M24;
      mpp           <= 24'd16777;
      wb            <= 23'd21627;
      prev_tacho    <= '0;
      x_accum       <= '0;
      y_accum       <= '0;
      heading_accum <= '0;
      seq_counter   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MPP: mpp <= cfg_data;
          REG_WB:  wb  <= cfg_data[22:0];
          default: mpp <= mpp;
        endcase
      end
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            neg        <= d[31];
            mag        <= d[31] ? ~d + 1'b1 : d;
            steer      <= in_word.steer_angle;
            el         <= in_word.elapsed_us;
            prev_tacho <= in_word.tacho_count;
            state      <= S_CH_GO;
          end
        end
        S_CH_GO: state <= S_CH_WAIT;
        S_CH_WAIT: begin
          if (cor_done) begin
            hc    <= cor_cos;
            hs    <= cor_sin;
            state <= S_CS_GO;
          end
        end
        S_CS_GO: state <= S_CS_WAIT;
        S_CS_WAIT: begin
          if (cor_done) begin
            sc    <= cor_cos;
            ss    <= cor_sin;
            op    <= OP_M24;
            state <= S_OP_GO;
          end
        end
        S_OP_GO: state <= S_OP_WAIT;
        S_OP_WAIT: begin
          if (md_rsp.done) begin
            unique case (op)
              OP_M24:   m24   <= prod[55:0];
              OP_STEPX: stepx <= prod[64:16];
              OP_STEPY: stepy <= prod[64:16];
              OP_DEN:   den   <= prod[39:0];
              OP_HP:    hp    <= prod[64:0];
              OP_HN:    hnum  <= prod[95:17];
              OP_HDIV:  hq    <= quo[15:0];
              OP_VN:    vnum  <= prod[75:0];
              OP_VDIV: begin
                vmag <= (md_rsp.ovf || quo > vlim) ? vlim[31:0] : quo[31:0];
              end
              OP_VX:    vxm   <= prod[48:16];
              OP_VY:    vym   <= prod[48:16];
              OP_YN:    yn    <= prod[48:0];
              OP_YDIV: begin
                yq   <= quo;
                yovf <= md_rsp.ovf;
              end
              default:  hq    <= hq;
            endcase
            if (op == OP_YDIV) begin
              state <= S_FIN;
            end else begin
              op    <= op + 1'b1;
              state <= S_OP_GO;
            end
          end
        end
        S_FIN: begin
          if (can_load) begin
            out_word.pos_x       <= mx[31:0];
            out_word.pos_y       <= my[31:0];
            out_word.heading_out <= heading_next;
            out_word.vel_x       <= vx_w;
            out_word.vel_y       <= vy_w;
            out_word.yaw_rate    <= yaw_w;
            out_word.seq_number  <= seq_counter;
            out_word.status      <= status_next;
            out_valid            <= 1'b1;
            x_accum              <= mx[31:0];
            y_accum              <= my[31:0];
            heading_accum        <= heading_next;
            seq_counter          <= seq_counter + 1'b1;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
